>>> rtl/ilir_pkg.sv
package ilir_pkg;

	// List geometry
	localparam int CAPACITY  = 256;
	localparam int WORD_BITS = 32;
	localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	// Fixed field widths of the command and result words
	localparam int CMD_W = 3;
	localparam int POS_W = 9;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;

	// Width used for every index and count comparison
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Read reduction tree: group size and group count
	localparam int GROUP_SIZE = 16;
	localparam int GROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ   = 3'd0,
		CMD_WRITE  = 3'd1,
		CMD_APPEND = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_REMOVE = 3'd4,
		CMD_RESIZE = 3'd5
	} cmd_e;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_e;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_LOAD,
		OP_SHIFT_UP,
		OP_SHIFT_DOWN
	} cell_op_e;

	// Broadcast control seen by every cell of the chain
	typedef struct packed {
		cell_op_e         op;
		logic [CMP_W-1:0] pos;
		logic [CMP_W-1:0] limit;
		word_t            value;
	} cell_ctrl_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] item_value;
		logic [POS_W-1:0] new_count;
	} in_word_t;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic [POS_W-1:0] count;
		logic [ST_W-1:0]  status;
	} out_word_t;

endpackage

>>> rtl/ilir_cell.sv
module ilir_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ilir_pkg::IDX_W-1:0] idx,
	input  ilir_pkg::cell_ctrl_t       ctrl,
	input  logic [ilir_pkg::POS_W-1:0] read_pos,
	input  ilir_pkg::word_t            left,
	input  ilir_pkg::word_t            right,
	output ilir_pkg::word_t            word,
	output ilir_pkg::word_t            tap
);

	ilir_pkg::word_t              word_q;
	logic [ilir_pkg::CMP_W-1:0]   me;
	logic                         at_pos;
	logic                         above_pos;
	logic                         below_limit;

	assign me          = ilir_pkg::CMP_W'(idx);
	assign at_pos      = (me == ctrl.pos);
	assign above_pos   = (me > ctrl.pos);
	assign below_limit = (me < ctrl.limit);

	// Load, take the left word on insert, take the right word on remove
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			case (ctrl.op)
				ilir_pkg::OP_LOAD: begin
					if (at_pos) word_q <= ctrl.value;
				end
				ilir_pkg::OP_SHIFT_UP: begin
					if (at_pos) word_q <= ctrl.value;
					else if (above_pos && below_limit) word_q <= left;
				end
				ilir_pkg::OP_SHIFT_DOWN: begin
					if ((at_pos || above_pos) && below_limit) word_q <= right;
				end
				default: begin
				end
			endcase
		end
	end

	assign word = word_q;
	// Offer the word to the read tree when this cell is addressed
	assign tap  = (me == ilir_pkg::CMP_W'(read_pos)) ? word_q : '0;

endmodule

>>> rtl/ilir_read_tree.sv
module ilir_read_tree (
	input  logic                       clk,
	input  logic                       en,
	input  ilir_pkg::word_t            taps [ilir_pkg::CAPACITY],
	output ilir_pkg::word_t            merged
);

	ilir_pkg::word_t group_c  [ilir_pkg::GROUPS];
	ilir_pkg::word_t group_s1 [ilir_pkg::GROUPS];

	// Merge each group of taps
	always_comb begin
		for (int g = 0; g < ilir_pkg::GROUPS; g++) begin
			group_c[g] = '0;
			for (int j = 0; j < ilir_pkg::GROUP_SIZE; j++) begin
				if (g * ilir_pkg::GROUP_SIZE + j < ilir_pkg::CAPACITY)
					group_c[g] = group_c[g] | taps[g * ilir_pkg::GROUP_SIZE + j];
			end
		end
	end

	// Hold the group results for the second level
	always_ff @(posedge clk) begin
		if (en) group_s1 <= group_c;
	end

	// Merge the groups
	always_comb begin
		merged = '0;
		for (int g = 0; g < ilir_pkg::GROUPS; g++)
			merged = merged | group_s1[g];
	end

endmodule

>>> rtl/indexed_list_insert_remove_top.sv
// Channel  | Ports                | Handshake
// ---------+----------------------+-------------------------------------------
// command  | start, busy, item    | word taken at an edge with start && !busy
// result   | done, result         | word shown for one cycle while done is high
//
// The accepting edge updates the chain of cells and captures the first
// level of the read tree; the next edge loads the result word. busy is
// high for the one cycle between. A new word may be taken while a result
// is shown.
// Reset clears every entry and the count at once; there is no clearing pass.
// The receiver cannot stall.
module indexed_list_insert_remove_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ilir_pkg::in_word_t  item,
	output logic                busy,
	output logic                done,
	output ilir_pkg::out_word_t result
);

	logic                         accept;
	ilir_pkg::cell_ctrl_t         ctrl;
	ilir_pkg::word_t              words [ilir_pkg::CAPACITY];
	ilir_pkg::word_t              taps  [ilir_pkg::CAPACITY];
	ilir_pkg::word_t              merged;

	logic [ilir_pkg::CNT_W-1:0]   count_q;
	logic [ilir_pkg::CMP_W-1:0]   pos_c, cnt_c, req_c, cap_c, next_cnt_c;
	ilir_pkg::status_e            status_c;
	logic                         rd_ok_c;

	logic                         valid_s1;
	ilir_pkg::status_e            status_s1;
	logic                         rd_ok_s1;
	logic [ilir_pkg::CMP_W-1:0]   count_s1;

	logic                         done_q;
	ilir_pkg::out_word_t          result_q;

	assign accept = start && !busy;
	assign pos_c  = ilir_pkg::CMP_W'(item.position);
	assign cnt_c  = ilir_pkg::CMP_W'(count_q);
	assign req_c  = ilir_pkg::CMP_W'(item.new_count);
	assign cap_c  = ilir_pkg::CMP_W'(ilir_pkg::CAPACITY);

	// Decode the command into cell control, status and next count
	always_comb begin
		ctrl.op    = ilir_pkg::OP_HOLD;
		ctrl.pos   = pos_c;
		ctrl.limit = cnt_c;
		ctrl.value = ilir_pkg::WORD_BITS'(item.item_value);
		status_c   = ilir_pkg::ST_OK;
		rd_ok_c    = 1'b0;
		next_cnt_c = cnt_c;
		case (ilir_pkg::cmd_e'(item.command))
			ilir_pkg::CMD_READ: begin
				if (pos_c < cnt_c) rd_ok_c = 1'b1;
				else status_c = ilir_pkg::ST_RANGE;
			end
			ilir_pkg::CMD_WRITE: begin
				if (pos_c < cnt_c) ctrl.op = ilir_pkg::OP_LOAD;
				else status_c = ilir_pkg::ST_RANGE;
			end
			ilir_pkg::CMD_APPEND: begin
				if (cnt_c >= cap_c) begin
					status_c = ilir_pkg::ST_FULL;
				end else begin
					ctrl.op    = ilir_pkg::OP_LOAD;
					ctrl.pos   = cnt_c;
					next_cnt_c = cnt_c + 1'b1;
				end
			end
			ilir_pkg::CMD_INSERT: begin
				if (pos_c > cnt_c) begin
					status_c = ilir_pkg::ST_RANGE;
				end else if (cnt_c >= cap_c) begin
					status_c = ilir_pkg::ST_FULL;
				end else begin
					ctrl.op    = ilir_pkg::OP_SHIFT_UP;
					ctrl.limit = cnt_c + 1'b1;
					next_cnt_c = cnt_c + 1'b1;
				end
			end
			ilir_pkg::CMD_REMOVE: begin
				if (pos_c >= cnt_c) begin
					status_c = ilir_pkg::ST_RANGE;
				end else begin
					ctrl.op    = ilir_pkg::OP_SHIFT_DOWN;
					ctrl.limit = cnt_c - 1'b1;
					next_cnt_c = cnt_c - 1'b1;
				end
			end
			ilir_pkg::CMD_RESIZE: begin
				if (req_c > cap_c) status_c = ilir_pkg::ST_FULL;
				else next_cnt_c = req_c;
			end
			default: begin
			end
		endcase
		// Drop the cell action unless the word is taken
		if (!accept) ctrl.op = ilir_pkg::OP_HOLD;
	end

	// Chain of cells, each linked to its neighbours
	for (genvar i = 0; i < ilir_pkg::CAPACITY; i++) begin : g_cell
		ilir_pkg::word_t left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_inner_l
			assign left_w = words[i-1];
		end
		if (i == ilir_pkg::CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner_r
			assign right_w = words[i+1];
		end
		ilir_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (ilir_pkg::IDX_W'(i)),
			.ctrl     (ctrl),
			.read_pos (item.position),
			.left     (left_w),
			.right    (right_w),
			.word     (words[i]),
			.tap      (taps[i])
		);
	end

	ilir_read_tree u_tree (
		.clk    (clk),
		.en     (accept),
		.taps   (taps),
		.merged (merged)
	);

	// Advance the count and flag the accepted command for the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) count_q <= ilir_pkg::CNT_W'(next_cnt_c);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_c;
			rd_ok_s1  <= rd_ok_c;
			count_s1  <= next_cnt_c;
		end
	end

	// Load the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q.read_value <= rd_ok_s1 ? ilir_pkg::VAL_W'(merged) : '0;
			result_q.count      <= ilir_pkg::POS_W'(count_s1);
			result_q.status     <= status_s1;
		end
	end

	assign busy   = valid_s1;
	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/ilir_checker.sv
module ilir_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input ilir_pkg::out_word_t result
);

	// An accepted word raises done once it has passed the valid_s1 and done_q registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result strobe missing two cycles after accept");

	// A result only follows an accepted word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result strobe without an accepted word");

	// busy lasts one cycle
	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	// Failed commands return a zero read value
	a_zero_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ilir_pkg::ST_OK) |-> (result.read_value == '0))
		else $error("non-zero read value on a failed command");

	// Count stays within capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(result.count) <= 32'(ilir_pkg::CAPACITY)))
		else $error("count beyond capacity");

endmodule

bind indexed_list_insert_remove_top ilir_checker u_ilir_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

>>> test/indexed_list_insert_remove_top_tb.sv
`timescale 1ns / 1ps

module indexed_list_insert_remove_top_tb;
	import ilir_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int PHASE_WORDS    = 300;

	typedef enum int {
		BIAS_GROW,
		BIAS_SHRINK,
		BIAS_MIXED
	} bias_e;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	in_word_t  item = '0;
	logic      busy;
	logic      done;
	out_word_t result;

	// Command words waiting to be driven and result words still owed
	in_word_t  pending_words[$];
	out_word_t expected_results[$];
	out_word_t oldest_result;

	// Shadow copy of the list, advanced as each command word is taken
	word_t list_mem [CAPACITY];
	int    list_len = 0;
	int    peak_len = 0;

	// Length the list will reach once every queued word has been applied
	int gen_len = 0;

	int issued_count = 0;
	int taken_count = 0;
	int sender_idle_pct = 0;
	int quiet_cycles = 0;
	int error_count = 0;
	int cmd_seen [8];
	int status_seen [4];

	indexed_list_insert_remove_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		error_count++;
	endtask

	// Apply one command word to the shadow list and return its result word
	function automatic out_word_t apply_list_command(input in_word_t w);
		out_word_t r;
		int        p;
		int        i;
		r = '0;
		r.status = ST_OK;
		p = w.position;
		case (w.command)
			CMD_READ: begin
				if (p < list_len) r.read_value = list_mem[p];
				else r.status = ST_RANGE;
			end
			CMD_WRITE: begin
				if (p < list_len) list_mem[p] = w.item_value[WORD_BITS-1:0];
				else r.status = ST_RANGE;
			end
			CMD_APPEND: begin
				if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					list_mem[list_len] = w.item_value[WORD_BITS-1:0];
					list_len++;
				end
			end
			CMD_INSERT: begin
				if (p > list_len) begin
					r.status = ST_RANGE;
				end else if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
					list_mem[p] = w.item_value[WORD_BITS-1:0];
					list_len++;
				end
			end
			CMD_REMOVE: begin
				// the vacated top slot keeps its old word
				if (p >= list_len) begin
					r.status = ST_RANGE;
				end else begin
					for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			CMD_RESIZE: begin
				if (w.new_count > CAPACITY) r.status = ST_FULL;
				else list_len = w.new_count;
			end
			default: begin
			end
		endcase
		r.count = list_len[POS_W-1:0];
		return r;
	endfunction

	// Queue one command word and track the length it leaves behind
	task automatic queue_word(input logic [CMD_W-1:0] cmd, input int pos, input word_t val,
			input int cnt);
		in_word_t w;
		w.command    = cmd;
		w.position   = pos[POS_W-1:0];
		w.item_value = val;
		w.new_count  = cnt[POS_W-1:0];
		pending_words.push_back(w);
		case (cmd)
			CMD_APPEND: if (gen_len < CAPACITY) gen_len++;
			CMD_INSERT: if (w.position <= gen_len && gen_len < CAPACITY) gen_len++;
			CMD_REMOVE: if (w.position < gen_len) gen_len--;
			CMD_RESIZE: if (w.new_count <= CAPACITY) gen_len = w.new_count;
			default: begin
			end
		endcase
	endtask

	// Queue random command words, steering the list length up and down in stretches
	task automatic queue_random(input int n);
		int               k;
		int               roll;
		int               pos;
		int               cnt;
		logic [CMD_W-1:0] cmd;
		logic [CMD_W-1:0] spare;
		word_t            val;
		bias_e            bias;
		bias = BIAS_MIXED;
		for (k = 0; k < n; k++) begin
			if (k % 40 == 0) bias = bias_e'($urandom_range(0, 2));
			roll  = $urandom_range(0, 99);
			spare = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
			case (bias)
				BIAS_GROW:
					cmd = (roll < 35) ? CMD_APPEND : (roll < 60) ? CMD_INSERT :
						(roll < 75) ? CMD_READ : (roll < 85) ? CMD_WRITE :
						(roll < 93) ? CMD_REMOVE : (roll < 97) ? CMD_RESIZE : spare;
				BIAS_SHRINK:
					cmd = (roll < 40) ? CMD_REMOVE : (roll < 60) ? CMD_READ :
						(roll < 75) ? CMD_WRITE : (roll < 85) ? CMD_APPEND :
						(roll < 93) ? CMD_INSERT : (roll < 97) ? CMD_RESIZE : spare;
				default:
					cmd = (roll < 20) ? CMD_READ : (roll < 40) ? CMD_WRITE :
						(roll < 55) ? CMD_APPEND : (roll < 70) ? CMD_INSERT :
						(roll < 85) ? CMD_REMOVE : (roll < 95) ? CMD_RESIZE : spare;
			endcase
			case ($urandom_range(0, 9))
				7:       pos = $urandom_range(0, 511);
				8:       pos = gen_len;
				9:       pos = ($urandom_range(0, 1)) ? CAPACITY - 1 : CAPACITY;
				default: pos = $urandom_range(0, gen_len);
			endcase
			case ($urandom_range(0, 9))
				5:       cnt = CAPACITY;
				6:       cnt = $urandom_range(CAPACITY - 16, CAPACITY);
				7:       cnt = $urandom_range(CAPACITY + 1, 511);
				8:       cnt = 0;
				9:       cnt = gen_len;
				default: cnt = $urandom_range(0, CAPACITY);
			endcase
			case ($urandom_range(0, 9))
				0:       val = '0;
				1:       val = '1;
				default: val = $urandom;
			endcase
			queue_word(cmd, pos, val, cnt);
		end
	endtask

	// Hold until every queued word is taken and every result word is back
	task automatic wait_for_drain();
		while (pending_words.size() != 0 || taken_count != issued_count ||
				expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Drive the next command word at the falling edge; hold one not yet taken
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && taken_count != issued_count)) begin
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				item         <= pending_words.pop_front();
				start        <= 1'b1;
				issued_count <= issued_count + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Check result words and predict for command words taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				status_seen[result.status]++;
				if (expected_results.size() == 0) begin
					flag_mismatch("result word with none expected");
				end else begin
					oldest_result = expected_results.pop_front();
					if (result.read_value !== oldest_result.read_value)
						flag_mismatch($sformatf("read_value %h, expected %h",
							result.read_value, oldest_result.read_value));
					if (result.count !== oldest_result.count)
						flag_mismatch($sformatf("count %0d, expected %0d",
							result.count, oldest_result.count));
					if (result.status !== oldest_result.status)
						flag_mismatch($sformatf("status %0d, expected %0d",
							result.status, oldest_result.status));
				end
			end
			if (start && !busy) begin
				expected_results.push_back(apply_list_command(item));
				if (list_len > peak_len) peak_len = list_len;
				cmd_seen[item.command]++;
				taken_count <= taken_count + 1;
			end
		end
	end

	// Drop the run if no word moves either way for too long
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		foreach (list_mem[i]) list_mem[i] = '0;
		foreach (cmd_seen[i]) cmd_seen[i] = 0;
		foreach (status_seen[i]) status_seen[i] = 0;

		// Directed words: empty list, boundaries, full list, spare codes
		sender_idle_pct = 36;
		queue_word(CMD_READ,   0,   32'h0000_0000, 0);
		queue_word(CMD_WRITE,  0,   32'hFFFF_FFFF, 0);
		queue_word(CMD_REMOVE, 0,   32'h0000_0000, 0);
		queue_word(CMD_INSERT, 1,   32'h1111_1111, 0);
		queue_word(CMD_INSERT, 0,   32'hFFFF_FFFF, 0);
		queue_word(CMD_APPEND, 0,   32'h0000_0000, 0);
		queue_word(CMD_APPEND, 0,   32'hA5A5_A5A5, 0);
		queue_word(CMD_INSERT, 3,   32'h1234_5678, 0);
		queue_word(CMD_INSERT, 1,   32'hDEAD_BEEF, 0);
		queue_word(CMD_WRITE,  1,   32'h0F0F_0F0F, 0);
		queue_word(CMD_READ,   1,   32'h0000_0000, 0);
		queue_word(CMD_REMOVE, 0,   32'h0000_0000, 0);
		queue_word(CMD_RESIZE, 0,   32'h0000_0000, CAPACITY + 1);
		queue_word(CMD_RESIZE, 0,   32'h0000_0000, CAPACITY);
		queue_word(CMD_READ,   255, 32'h0000_0000, 0);
		queue_word(CMD_READ,   256, 32'h0000_0000, 0);
		queue_word(CMD_WRITE,  255, 32'hFFFF_FFFF, 0);
		queue_word(CMD_APPEND, 0,   32'h5555_5555, 0);
		queue_word(CMD_INSERT, 256, 32'h5555_5555, 0);
		queue_word(CMD_INSERT, 257, 32'h5555_5555, 0);
		queue_word(CMD_SPARE_LO, 2, 32'hFFFF_FFFF, 511);
		queue_word(CMD_SPARE_HI, 511, 32'hFFFF_FFFF, 511);
		queue_word(CMD_REMOVE, 3,   32'h0000_0000, 0);
		queue_word(CMD_RESIZE, 0,   32'h0000_0000, CAPACITY);
		queue_word(CMD_READ,   255, 32'h0000_0000, 0);
		queue_word(CMD_READ,   511, 32'h0000_0000, 0);
		queue_word(CMD_RESIZE, 0,   32'h0000_0000, 0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Random phases: light sender idling, heavy idling, then none
		queue_random(PHASE_WORDS);
		wait_for_drain();
		sender_idle_pct = 65;
		queue_random(PHASE_WORDS);
		wait_for_drain();
		sender_idle_pct = 0;
		queue_random(PHASE_WORDS);
		wait_for_drain();

		$display("Covered %0d command words: read %0d, write %0d, append %0d, insert %0d, %s",
			taken_count, cmd_seen[CMD_READ], cmd_seen[CMD_WRITE], cmd_seen[CMD_APPEND],
			cmd_seen[CMD_INSERT], $sformatf("remove %0d, resize %0d, spare codes %0d",
			cmd_seen[CMD_REMOVE], cmd_seen[CMD_RESIZE],
			cmd_seen[CMD_SPARE_LO] + cmd_seen[CMD_SPARE_HI]));
		$display("Result status ok %0d, out of range %0d, full %0d; list length peaked at %0d",
			status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL], peak_len);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
